### rtl/mavrm_pkg.sv
package mavrm_pkg;

   localparam int TIME_W = 32;
   localparam int RATE_W = 24;
   localparam int FRAC_W = 8;
   localparam int STEP_W = $clog2(RATE_W + 1);

   localparam logic [RATE_W-1:0] RATE_MAX     = {RATE_W{1'b1}};
   localparam logic [RATE_W-1:0] STABLE_RESET = RATE_W'(15360);   // 60.0 in Q16.8
   localparam logic [TIME_W-1:0] TICK_RESET   = TIME_W'(1000000);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_START,
      ST_DIVIDE,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic              done;
      logic [RATE_W-1:0] quotient;
   } div_rsp_type;

endpackage

### rtl/mavrm_ram.sv
module mavrm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/mavrm_div.sv
module mavrm_div import mavrm_pkg::*; #(
   parameter int SUM_W = 38
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [SUM_W+FRAC_W-1:0]   num,
   input  logic [SUM_W-1:0]          den,
   output div_rsp_type               rsp
);

   localparam int NUM_W = SUM_W + FRAC_W;

   logic              busy_ff,  busy_in;
   logic              done_ff,  done_in;
   logic              sat_ff,   sat_in;
   logic [STEP_W-1:0] cnt_ff,   cnt_in;
   logic [SUM_W-1:0]  rem_ff,   rem_in;
   logic [RATE_W-1:0] shf_ff,   shf_in;
   logic [SUM_W-1:0]  den_ff,   den_in;

   logic [SUM_W-1:0]  num_hi;
   logic [SUM_W:0]    trial;
   logic [SUM_W:0]    diff;

   assign num_hi = SUM_W'(num[NUM_W-1:RATE_W]);
   assign trial  = {rem_ff, shf_ff[RATE_W-1]};
   assign diff   = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      shf_in  = shf_ff;
      den_in  = den_ff;
      if (start) begin
         den_in = den;
         rem_in = num_hi;
         shf_in = num[RATE_W-1:0];
         cnt_in = STEP_W'(RATE_W);
         // quotient cannot fit (or zero divisor): skip the iterations
         if (num_hi >= den) begin
            sat_in  = 1'b1;
            done_in = 1'b1;
         end else begin
            sat_in  = 1'b0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         // restoring step: one quotient bit per cycle
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[SUM_W-1:0];
            shf_in = {shf_ff[RATE_W-2:0], 1'b1};
         end else begin
            rem_in = trial[SUM_W-1:0];
            shf_in = {shf_ff[RATE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sat_ff <= sat_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      shf_ff <= shf_in;
      den_ff <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = sat_ff ? RATE_MAX : shf_ff;

endmodule

### rtl/moving_average_rate_meter.sv
// Moving-average frame rate meter, one item in flight at a time.
// An accepted item updates the sum, then the restoring divider runs; a rate
// that saturates (zero sum or quotient over 24 bits) skips the divide steps.
// The divider retires one quotient bit per cycle. A new item is taken only
// after the last result is loaded into the output register, which waits while a stalled result holds it.
// Reset (synchronous, active high): ring reads as zero, sum and index zero,
// tick rate 1000000 Hz, stable rate 60.0; no clearing pass is needed.
module moving_average_rate_meter import mavrm_pkg::*; #(
   parameter int SAMPLES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [TIME_W-1:0] csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [TIME_W-1:0] req_frame_time,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [RATE_W-1:0] rsp_rate,
   output logic [RATE_W-1:0] rsp_stable_rate
);

   localparam int IDX_W = $clog2(SAMPLES);
   localparam int SUM_W = TIME_W + IDX_W;        // exact sum of SAMPLES intervals
   localparam int NUM_W = SUM_W + FRAC_W;        // tick * SAMPLES in Q.8
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES - 1);

   state_type         state_ff,     state_in;
   logic [TIME_W-1:0] tick_ff,      tick_in;
   logic [TIME_W-1:0] last_time_ff, last_time_in;
   logic [TIME_W-1:0] delta_ff,     delta_in;
   logic [SUM_W-1:0]  sum_ff,       sum_in;
   logic [NUM_W-1:0]  num_ff,       num_in;
   logic [IDX_W-1:0]  index_ff,     index_in;
   logic              wrapped_ff,   wrapped_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0] rate_ff,      rate_in;
   logic [RATE_W-1:0] stable_ff,    stable_in;

   logic              accept;
   logic              ram_rd_en;
   logic              ram_wr_en;
   logic [TIME_W-1:0] ram_rd_data;
   logic [TIME_W-1:0] old_delta;
   logic [SUM_W-1:0]  product;
   logic              div_start;
   div_rsp_type       div_rsp;

   assign accept = req_valid && (state_ff == ST_IDLE);

   // Ring slots fill in order, so before the first wrap the slot about to be
   // overwritten was never written; its read data is replaced by zero.
   assign old_delta = wrapped_ff ? ram_rd_data : '0;
   assign product   = SUM_W'(tick_ff) * SUM_W'(SAMPLES);

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      last_time_in = last_time_ff;
      delta_in     = delta_ff;
      sum_in       = sum_ff;
      num_in       = num_ff;
      index_in     = index_ff;
      wrapped_in   = wrapped_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rate_in      = rate_ff;
      stable_in    = stable_ff;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;
      div_start    = 1'b0;

      if (csr_wr_en) begin
         tick_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // interval modulo 2^32; fetch the slot it replaces
               delta_in     = req_frame_time - last_time_ff;
               last_time_in = req_frame_time;
               ram_rd_en    = 1'b1;
               state_in     = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            ram_wr_en = 1'b1;
            sum_in    = sum_ff - SUM_W'(old_delta) + SUM_W'(delta_ff);
            num_in    = {product, FRAC_W'(0)};
            if (index_ff == LAST_IDX) begin
               index_in   = '0;
               wrapped_in = 1'b1;
            end else begin
               index_in = index_ff + IDX_W'(1);
            end
            state_in = ST_START;
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            // output register free or being emptied this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rate_in      = div_rsp.quotient;
               if (index_ff == '0) begin
                  stable_in = div_rsp.quotient;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= TICK_RESET;
         last_time_ff <= '0;
         sum_ff       <= '0;
         index_ff     <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         stable_ff    <= STABLE_RESET;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         last_time_ff <= last_time_in;
         sum_ff       <= sum_in;
         index_ff     <= index_in;
         wrapped_ff   <= wrapped_in;
         rsp_valid_ff <= rsp_valid_in;
         stable_ff    <= stable_in;
      end
      delta_ff <= delta_in;
      num_ff   <= num_in;
      rate_ff  <= rate_in;
   end

   // interval ring
   mavrm_ram #(
      .WIDTH (TIME_W),
      .DEPTH (SAMPLES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (index_ff),
      .wr_data (delta_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (index_ff),
      .rd_data (ram_rd_data)
   );

   // iterative divider: tick * SAMPLES * 256 / sum, saturating
   mavrm_div #(
      .SUM_W (SUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (sum_ff),
      .rsp   (div_rsp)
   );

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rate        = rate_ff;
   assign rsp_stable_rate = stable_ff;

endmodule

### rtl/mavrm_checker.sv
module mavrm_checker import mavrm_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [RATE_W-1:0] rsp_stable_rate
);

   // result held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   // one item in flight: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after accept");

   // a new result only comes out of a busy block
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without work");

   // stable rate moves only together with a delivered result
   a_stable_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(rsp_stable_rate)) |-> rsp_valid)
      else $error("stable rate changed without a result");

endmodule

bind moving_average_rate_meter mavrm_checker u_mavrm_checker (.*);
